/* src/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants for the ARP cache and responder
// Holds the request and response word formats, the command word that passes
// from the front to the back, and the protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none
package arpc_pkg;

   localparam int CacheEntries = 32;
   localparam int IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
   localparam int CntW = $clog2(CacheEntries + 1);
   localparam int QueueDepth = 2;
   localparam int QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW = $clog2(QueueDepth + 1);

   localparam logic [10:0] MinArpLen = 11'd28;
   localparam logic [15:0] OpRequest = 16'd1;
   localparam logic [1:0]  KindNone = 2'd0;
   localparam logic [1:0]  KindRequest = 2'd1;
   localparam logic [1:0]  KindReply = 2'd2;

   localparam logic CsrOwnIp = 1'b0;
   localparam logic CsrOwnMac = 1'b1;

   typedef struct packed {
      logic        func;
      logic [10:0] pkt_len;
      logic [15:0] arp_opcode;
      logic [31:0] peer_ip;
      logic [47:0] peer_mac;
      logic [31:0] asked_ip;
      logic [31:0] lookup_ip;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  tx_kind;
      logic [47:0] eth_dest;
      logic [47:0] out_target_mac;
      logic [31:0] out_target_ip;
      logic        hit;
      logic [47:0] found_mac;
   } rsp_word_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic        drop;      // short packet: answer all zero
      logic        resolve;   // resolve query, else packet store
      logic        reply;     // packet is a request for our address
      logic [31:0] key_ip;    // address to search for
      logic [47:0] peer_mac;
   } cmd_type;

endpackage
`default_nettype wire

/* src/arpc_front.sv */
// ----------------------------------------------------------------------------
// arpc_front: request classifier and command queue
// Decodes each request word against the own address and queues a command.
// ----------------------------------------------------------------------------
`default_nettype none
module arpc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire arpc_pkg::req_word_type req_data,
   input  wire logic [31:0]           own_ip,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output arpc_pkg::cmd_type          cmd_data
);

   localparam int PW = arpc_pkg::QueuePtrW;
   localparam int QW = arpc_pkg::QueueCntW;

   arpc_pkg::cmd_type q_ff [arpc_pkg::QueueDepth];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW-1:0]     count_ff, count_in;
   arpc_pkg::cmd_type cmd_new;
   logic              push, pop;

   always_comb begin
      cmd_new.drop = ~req_data.func && (req_data.pkt_len < arpc_pkg::MinArpLen);
      cmd_new.resolve = req_data.func;
      cmd_new.reply = (req_data.arp_opcode == arpc_pkg::OpRequest)
                      && (req_data.asked_ip == own_ip);
      cmd_new.key_ip = req_data.func ? req_data.lookup_ip : req_data.peer_ip;
      cmd_new.peer_mac = req_data.peer_mac;
   end

   assign req_ready = (count_ff != QW'(arpc_pkg::QueueDepth));
   assign push = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(arpc_pkg::QueueDepth - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(arpc_pkg::QueueDepth - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + QW'(push) - QW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule
`default_nettype wire

/* src/arpc_back.sv */
// ----------------------------------------------------------------------------
// arpc_back: cache walker and response builder
// Walks the cache one entry a cycle, then stores packets and builds responses.
// ----------------------------------------------------------------------------
`default_nettype none
module arpc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire arpc_pkg::cmd_type     cmd_data,
   input  wire logic [47:0]           own_mac,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output arpc_pkg::rsp_word_type     rsp_data
);

   localparam int N = arpc_pkg::CacheEntries;
   localparam int IW = arpc_pkg::IdxW;
   localparam int CW = arpc_pkg::CntW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   logic [31:0] ip_mem [N];
   logic [47:0] mac_mem [N];
   logic [N-1:0] valid_ff, valid_in;

   state_type         state_ff, state_in;
   arpc_pkg::cmd_type cmd_ff;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     found_idx_ff, found_idx_in;
   logic              free_ff, free_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic [31:0]       rd_ip_ff;
   logic [47:0]       rd_mac_ff, found_mac_ff, found_mac_in;
   logic              rd_live_ff, rd_live_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   arpc_pkg::rsp_word_type rsp_ff, rsp_in;
   logic              wr_en;
   logic [IW-1:0]     wr_idx;
   logic              set_valid;
   logic              hit_now;

   assign cmd_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Registered read of the entry addressed last cycle is compared now.
   assign hit_now = rd_live_ff && valid_ff[rd_idx_ff] && (rd_ip_ff == cmd_ff.key_ip);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      found_mac_in = found_mac_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      rd_live_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_idx = found_idx_ff;
      set_valid = 1'b0;
      valid_in = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               idx_in = '0;
               found_in = 1'b0;
               free_in = 1'b0;
               state_in = cmd_data.drop ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (hit_now && !found_ff) begin
               found_in = 1'b1;
               found_idx_in = rd_idx_ff;
               found_mac_in = rd_mac_ff;
            end
            if (idx_ff < CW'(N)) begin
               rd_live_in = 1'b1;
               rd_idx_in = idx_ff[IW-1:0];
               if (!valid_ff[idx_ff[IW-1:0]] && !free_ff) begin
                  free_in = 1'b1;
                  free_idx_in = idx_ff[IW-1:0];
               end
               idx_in = idx_ff + CW'(1);
            end else if (!rd_live_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_in = '0;
               if (cmd_ff.drop) begin
                  rsp_in = '0;
               end else if (cmd_ff.resolve) begin
                  if (found_ff) begin
                     rsp_in.hit = 1'b1;
                     rsp_in.found_mac = found_mac_ff;
                  end else begin
                     rsp_in.tx_kind = arpc_pkg::KindRequest;
                     rsp_in.eth_dest = '1;
                     rsp_in.out_target_ip = cmd_ff.key_ip;
                  end
               end else begin
                  if (found_ff) begin
                     wr_en = 1'b1;
                     wr_idx = found_idx_ff;
                  end else if (free_ff) begin
                     wr_en = 1'b1;
                     wr_idx = free_idx_ff;
                     set_valid = 1'b1;
                  end
                  if (cmd_ff.reply) begin
                     rsp_in.tx_kind = arpc_pkg::KindReply;
                     rsp_in.eth_dest = cmd_ff.peer_mac;
                     rsp_in.out_target_mac = cmd_ff.peer_mac;
                     rsp_in.out_target_ip = cmd_ff.key_ip;
                  end
               end
               if (set_valid) begin
                  valid_in[wr_idx] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff <= rd_live_in;
      end
      if (cmd_valid && cmd_ready) begin
         cmd_ff <= cmd_data;
      end
      idx_ff <= idx_in;
      found_ff <= found_in;
      found_idx_ff <= found_idx_in;
      found_mac_ff <= found_mac_in;
      free_ff <= free_in;
      free_idx_ff <= free_idx_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff <= rsp_in;
   end

   // Cache memories: one read port for the walk, one write port for the update.
   always_ff @(posedge clock) begin
      rd_ip_ff <= ip_mem[idx_ff[IW-1:0]];
      rd_mac_ff <= mac_mem[idx_ff[IW-1:0]];
      if (wr_en) begin
         mac_mem[wr_idx] <= cmd_ff.peer_mac;
         if (set_valid) begin
            ip_mem[wr_idx] <= cmd_ff.key_ip;
         end
      end
   end

   // own_mac is the sender address of sent packets; it is not part of the
   // response word, so nothing here depends on it.
   logic own_mac_unused;
   assign own_mac_unused = ^own_mac;

endmodule
`default_nettype wire

/* src/arp_cache_and_responder.sv */
// ----------------------------------------------------------------------------
// arp_cache_and_responder: IPv4 ARP cache with responder
// Top level: configuration registers, front classifier and back cache walker.
// ----------------------------------------------------------------------------
// Each request word is classified at the front and queued (two deep); the
// back then walks all 32 cache entries, one entry a cycle through the single
// read port of the cache memory. Words are handled one at a time: the back
// takes the next command only once the response has been taken. Short
// packets skip the walk. A received packet stores the sender pair (existing
// entry first, else the lowest free entry, else it is dropped) and answers a
// request for own_ip with a reply; a resolve query returns the cached MAC or
// a broadcast request. Valid bits sit in flip-flops and clear at reset, so
// no clearing pass is needed. The response waits in an output register while
// the next word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module arp_cache_and_responder (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire arpc_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output arpc_pkg::rsp_word_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [0:0]             csr_index,
   input  wire logic [47:0]            csr_wdata
);

   logic [31:0]       own_ip_ff;
   logic [47:0]       own_mac_ff;
   logic              cmd_valid, cmd_ready;
   arpc_pkg::cmd_type cmd_data;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
         own_mac_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index[0])
            arpc_pkg::CsrOwnIp:  own_ip_ff <= csr_wdata[31:0];
            arpc_pkg::CsrOwnMac: own_mac_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   arpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .own_ip    (own_ip_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   arpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .own_mac   (own_mac_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
